// ===== sv/grid_cell_range_query_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Grid cell range query: assertion macros
// Shared assertion forms for the range query modules.
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_RANGE_QUERY_UNIT_DEFINES_SVH
`define GRID_CELL_RANGE_QUERY_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GCRQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GCRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gcrq_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid cell range query: package
// Shared types, register indexes and cell position codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gcrq_pkg;

  localparam int CELL_WIDTH_DEF  = 16;
  localparam int CELL_HEIGHT_DEF = 16;

  // reciprocal precision for the cell split
  localparam int RECIP_SHIFT = 26;

  localparam int QUEUE_DEPTH = 4;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  localparam logic [8:0] GRID_RESET = 9'd64;

  // emit order of the cells, also the bit positions in a job mask
  localparam logic [3:0] POS_OWN   = 4'd0;
  localparam logic [3:0] POS_UP    = 4'd1;
  localparam logic [3:0] POS_UR    = 4'd2;
  localparam logic [3:0] POS_RIGHT = 4'd3;
  localparam logic [3:0] POS_DR    = 4'd4;
  localparam logic [3:0] POS_DOWN  = 4'd5;
  localparam logic [3:0] POS_DL    = 4'd6;
  localparam logic [3:0] POS_LEFT  = 4'd7;
  localparam logic [3:0] POS_UL    = 4'd8;

  typedef struct packed {
    logic [8:0] grid_columns;
    logic [8:0] grid_rows;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  mask;   // cells to emit, bit per position code
    logic [15:0] base;   // index of the own cell
    logic [8:0]  ncols;  // clamped column count
  } job_t;

endpackage

`default_nettype wire

// ===== sv/gcrq_front.sv =====
// ----------------------------------------------------------------------------
// Grid cell range query: front pipeline
// Splits the position into cell and offset and classifies the neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrq_front #(
  parameter int CELL_WIDTH  = gcrq_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT = gcrq_pkg::CELL_HEIGHT_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [47:0]         s_tdata,
  input  gcrq_pkg::cfg_t      cfg,
  output logic                push,
  output gcrq_pkg::job_t      job,
  input  wire                 full
);

  localparam int REC_W  = gcrq_pkg::RECIP_SHIFT + 1;
  localparam int PROD_W = 16 + REC_W;
  localparam int DX_W   = $clog2(CELL_WIDTH + 1);
  localparam int DY_W   = $clog2(CELL_HEIGHT + 1);
  localparam int RX_W   = $clog2(2 * CELL_WIDTH);
  localparam int RY_W   = $clog2(2 * CELL_HEIGHT);
  localparam int DM_W   = (DX_W > DY_W) ? DX_W : DY_W;
  localparam int SQ_W   = 2 * DM_W;

  localparam logic [REC_W-1:0] RECIP_X =
    REC_W'((64'd1 << gcrq_pkg::RECIP_SHIFT) / CELL_WIDTH);
  localparam logic [REC_W-1:0] RECIP_Y =
    REC_W'((64'd1 << gcrq_pkg::RECIP_SHIFT) / CELL_HEIGHT);

  logic adv;

  // stage 1: reciprocal multiply
  logic        s1_valid;
  logic [15:0] s1_px, s1_py, s1_r, s1_qx, s1_qy;
  logic [PROD_W-1:0] prod_x, prod_y;

  // stage 2: remainder
  logic        s2_valid;
  logic [15:0] s2_qx, s2_qy, s2_r;
  logic [RX_W-1:0] s2_remx;
  logic [RY_W-1:0] s2_remy;
  logic [16:0] rem_x17, rem_y17;

  // stage 3: corrected quotient and offset
  logic        s3_valid;
  logic [15:0] s3_qx, s3_qy, s3_r;
  logic [DX_W-1:0] s3_offx;
  logic [DY_W-1:0] s3_offy;
  logic [15:0] qx_fix, qy_fix;
  logic [DX_W-1:0] offx_fix;
  logic [DY_W-1:0] offy_fix;

  // stage 4: clamp, distances, squares
  logic        s4_valid;
  logic        s4_e_up, s4_e_right, s4_e_down, s4_e_left;
  logic [SQ_W-1:0] s4_sq_up, s4_sq_right, s4_sq_down, s4_sq_left;
  logic [31:0] s4_r2;
  logic [15:0] s4_base;
  logic [8:0]  s4_ncols;

  logic [8:0]  ncols_c, nrows_c;
  logic [7:0]  cx, cy;
  logic [DX_W-1:0] d_left, d_right;
  logic [DY_W-1:0] d_up, d_down;
  logic        has_up, has_right, has_down, has_left;
  logic        c_ur, c_dr, c_dl, c_ul;

  assign adv      = !s4_valid || !full;
  assign s_tready = adv;
  assign push     = s4_valid && !full;

  assign prod_x = PROD_W'(s_tdata[15:0]) * PROD_W'(RECIP_X);
  assign prod_y = PROD_W'(s_tdata[31:16]) * PROD_W'(RECIP_Y);

  assign rem_x17 = {1'b0, s1_px} - 17'(17'(s1_qx) * 17'(CELL_WIDTH));
  assign rem_y17 = {1'b0, s1_py} - 17'(17'(s1_qy) * 17'(CELL_HEIGHT));

  // estimate is low by at most one
  always_comb begin
    if (s2_remx >= RX_W'(CELL_WIDTH)) begin
      qx_fix   = s2_qx + 16'd1;
      offx_fix = DX_W'(s2_remx - RX_W'(CELL_WIDTH));
    end else begin
      qx_fix   = s2_qx;
      offx_fix = DX_W'(s2_remx);
    end
    if (s2_remy >= RY_W'(CELL_HEIGHT)) begin
      qy_fix   = s2_qy + 16'd1;
      offy_fix = DY_W'(s2_remy - RY_W'(CELL_HEIGHT));
    end else begin
      qy_fix   = s2_qy;
      offy_fix = DY_W'(s2_remy);
    end
  end

  always_comb begin
    priority if (cfg.grid_columns == 9'd0) ncols_c = 9'd1;
    else if (cfg.grid_columns > 9'd256)    ncols_c = 9'd256;
    else                                   ncols_c = cfg.grid_columns;
    priority if (cfg.grid_rows == 9'd0)    nrows_c = 9'd1;
    else if (cfg.grid_rows > 9'd256)       nrows_c = 9'd256;
    else                                   nrows_c = cfg.grid_rows;

    // saturate a centre beyond the grid to the last column or row
    if (s3_qx >= 16'(ncols_c)) cx = 8'(ncols_c - 9'd1);
    else                       cx = s3_qx[7:0];
    if (s3_qy >= 16'(nrows_c)) cy = 8'(nrows_c - 9'd1);
    else                       cy = s3_qy[7:0];

    has_up    = cy != 8'd0;
    has_left  = cx != 8'd0;
    has_right = (9'(cx) + 9'd1) < ncols_c;
    has_down  = (9'(cy) + 9'd1) < nrows_c;

    d_left  = s3_offx;
    d_up    = s3_offy;
    d_right = DX_W'(CELL_WIDTH) - s3_offx;
    d_down  = DY_W'(CELL_HEIGHT) - s3_offy;
  end

  always_comb begin
    c_ur = (32'(s4_sq_up) + 32'(s4_sq_right)) < s4_r2;
    c_dr = (32'(s4_sq_right) + 32'(s4_sq_down)) < s4_r2;
    c_dl = (32'(s4_sq_down) + 32'(s4_sq_left)) < s4_r2;
    c_ul = (32'(s4_sq_left) + 32'(s4_sq_up)) < s4_r2;

    job.mask                     = '0;
    job.mask[gcrq_pkg::POS_OWN]   = 1'b1;
    job.mask[gcrq_pkg::POS_UP]    = s4_e_up;
    job.mask[gcrq_pkg::POS_UR]    = s4_e_up && s4_e_right && c_ur;
    job.mask[gcrq_pkg::POS_RIGHT] = s4_e_right;
    job.mask[gcrq_pkg::POS_DR]    = s4_e_right && s4_e_down && c_dr;
    job.mask[gcrq_pkg::POS_DOWN]  = s4_e_down;
    job.mask[gcrq_pkg::POS_DL]    = s4_e_down && s4_e_left && c_dl;
    job.mask[gcrq_pkg::POS_LEFT]  = s4_e_left;
    job.mask[gcrq_pkg::POS_UL]    = s4_e_left && s4_e_up && c_ul;
    job.base                     = s4_base;
    job.ncols                    = s4_ncols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px <= s_tdata[15:0];
      s1_py <= s_tdata[31:16];
      s1_r  <= s_tdata[47:32];
      s1_qx <= prod_x[gcrq_pkg::RECIP_SHIFT +: 16];
      s1_qy <= prod_y[gcrq_pkg::RECIP_SHIFT +: 16];

      s2_qx   <= s1_qx;
      s2_qy   <= s1_qy;
      s2_r    <= s1_r;
      s2_remx <= rem_x17[RX_W-1:0];
      s2_remy <= rem_y17[RY_W-1:0];

      s3_qx   <= qx_fix;
      s3_qy   <= qy_fix;
      s3_offx <= offx_fix;
      s3_offy <= offy_fix;
      s3_r    <= s2_r;

      s4_e_up     <= has_up && (s3_r > 16'(d_up));
      s4_e_right  <= has_right && (s3_r > 16'(d_right));
      s4_e_down   <= has_down && (s3_r > 16'(d_down));
      s4_e_left   <= has_left && (s3_r > 16'(d_left));
      s4_sq_up    <= SQ_W'(d_up) * SQ_W'(d_up);
      s4_sq_right <= SQ_W'(d_right) * SQ_W'(d_right);
      s4_sq_down  <= SQ_W'(d_down) * SQ_W'(d_down);
      s4_sq_left  <= SQ_W'(d_left) * SQ_W'(d_left);
      s4_r2       <= 32'(s3_r) * 32'(s3_r);
      s4_base     <= 16'(17'(cy) * 17'(ncols_c) + 17'(cx));
      s4_ncols    <= ncols_c;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gcrq_queue.sv =====
// ----------------------------------------------------------------------------
// Grid cell range query: job queue
// Short FIFO of classified queries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcrq_queue #(
  parameter int DEPTH = gcrq_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_en,
  input  gcrq_pkg::job_t      wr_data,
  output logic                full,
  input  wire                 rd_en,
  output gcrq_pkg::job_t      rd_data,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gcrq_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gcrq_back.sv =====
// ----------------------------------------------------------------------------
// Grid cell range query: back sequencer
// Walks a job mask and emits one cell index per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_cell_range_query_unit_defines.svh"

module gcrq_back (
  input  wire                 clk,
  input  wire                 rst,
  input  gcrq_pkg::job_t      q_data,
  input  wire                 q_empty,
  output logic                q_rd,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [15:0]         m_tdata,   // cell_index[15:0]
  output logic                m_tlast
);

  logic [8:0]  cur_mask, next_mask;
  logic [15:0] cur_base, cell_idx;
  logic [8:0]  cur_ncols;
  logic [3:0]  sel;
  logic        cur_busy, emit, done;

  assign cur_busy  = cur_mask != '0;
  assign emit      = cur_busy && (!m_tvalid || m_tready);
  assign done      = next_mask == '0;
  assign q_rd      = !q_empty && (!cur_busy || (emit && done));

  always_comb begin
    sel = gcrq_pkg::POS_OWN;
    for (int i = 8; i >= 0; i--) begin
      if (cur_mask[i]) sel = 4'(i);
    end
    next_mask      = cur_mask;
    next_mask[sel] = 1'b0;
  end

  always_comb begin
    unique case (sel)
      gcrq_pkg::POS_UP:    cell_idx = cur_base - 16'(cur_ncols);
      gcrq_pkg::POS_UR:    cell_idx = cur_base - 16'(cur_ncols) + 16'd1;
      gcrq_pkg::POS_RIGHT: cell_idx = cur_base + 16'd1;
      gcrq_pkg::POS_DR:    cell_idx = cur_base + 16'(cur_ncols) + 16'd1;
      gcrq_pkg::POS_DOWN:  cell_idx = cur_base + 16'(cur_ncols);
      gcrq_pkg::POS_DL:    cell_idx = cur_base + 16'(cur_ncols) - 16'd1;
      gcrq_pkg::POS_LEFT:  cell_idx = cur_base - 16'd1;
      gcrq_pkg::POS_UL:    cell_idx = cur_base - 16'(cur_ncols) - 16'd1;
      default:             cell_idx = cur_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // load the next job as the current one drains
      if (q_rd) begin
        cur_mask <= q_data.mask;
      end else if (emit) begin
        cur_mask <= next_mask;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_base  <= q_data.base;
      cur_ncols <= q_data.ncols;
    end
    if (emit) begin
      m_tdata <= cell_idx;
      m_tlast <= done;
    end
  end

  `GCRQ_ASSERT_NOW(a_own_cell_first, clk, rst, q_rd, q_data.mask[gcrq_pkg::POS_OWN], "job without own cell")
  `GCRQ_ASSERT_NOW(a_rest_pending, clk, rst, m_tvalid && !m_tlast, cur_busy, "query cut short")
  `GCRQ_ASSERT_NEXT(a_handoff, clk, rst, emit && done && !q_empty, cur_busy, "queued job not picked up")

endmodule

`default_nettype wire

// ===== sv/grid_cell_range_query_unit.sv =====
// ----------------------------------------------------------------------------
// Grid cell range query unit
// Emits the linear indices of the grid cells that a query circle reaches.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: pos_x, pos_y, radius
//  m_*      | out       | tdata: cell_index; tlast: last cell of the query
//  cfg_*    | in        | register writes: grid_columns, grid_rows
//
//  A query emits 1 to 9 cells through the back sequencer, which drives the
//  single output register.
//  An accepted query passes the front's s1 to s4 registers to the job queue.
//  Reset clears the pipeline, queue and output; both grid sizes go to 64.
//  An output stall fills the queue, then the front holds and drops tready.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_range_query_unit #(
  parameter int CELL_WIDTH  = gcrq_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT = gcrq_pkg::CELL_HEIGHT_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [47:0] s_tdata,    // pos_x[15:0], pos_y[31:16], radius[47:32]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,    // cell_index[15:0]
  output logic        m_tlast,
  input  wire         cfg_wr_en,
  input  wire         cfg_index,
  input  wire  [8:0]  cfg_data
);

  gcrq_pkg::cfg_t cfg;
  gcrq_pkg::job_t push_job, head_job;
  logic           push, full, empty, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_columns <= gcrq_pkg::GRID_RESET;
      cfg.grid_rows    <= gcrq_pkg::GRID_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == gcrq_pkg::REG_GRID_COLUMNS) begin
        cfg.grid_columns <= cfg_data;
      end else begin
        cfg.grid_rows <= cfg_data;
      end
    end
  end

  gcrq_front #(
    .CELL_WIDTH  (CELL_WIDTH),
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .push     (push),
    .job      (push_job),
    .full     (full)
  );

  gcrq_queue #(
    .DEPTH (gcrq_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (push_job),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head_job),
    .empty   (empty)
  );

  gcrq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (head_job),
    .q_empty  (empty),
    .q_rd     (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
